[hdl/cliprs_pkg.sv]
// ----------------------------------------------------------------------------
// cliprs_pkg
// Shared types, constants and the rectangle trim function of the clip stack.
// ----------------------------------------------------------------------------
package cliprs_pkg;

  localparam int CoordW = 16;
  localparam int WinW   = 15;
  localparam int CfgIdxW = 1;
  // wide enough that no step of the trim can wrap
  localparam int TrimW  = 22;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_HEIGHT = 1'b1;

  localparam logic [WinW-1:0] WINDOW_WIDTH_RST  = 15'd768;
  localparam logic [WinW-1:0] WINDOW_HEIGHT_RST = 15'd432;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] w;
    logic signed [CoordW-1:0] h;
  } clip_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic commit;
  } ctl_cmd_t;

  // trim a rectangle to a clip; the result always fits in 16 signed bits
  function automatic clip_t trim_clip(clip_t r, clip_t c);
    logic signed [TrimW-1:0] rx;
    logic signed [TrimW-1:0] ry;
    logic signed [TrimW-1:0] rw;
    logic signed [TrimW-1:0] rh;
    logic signed [TrimW-1:0] cx;
    logic signed [TrimW-1:0] cy;
    logic signed [TrimW-1:0] cw;
    logic signed [TrimW-1:0] ch;
    logic signed [TrimW-1:0] d;
    clip_t t;
    rx = TrimW'(r.x);
    ry = TrimW'(r.y);
    rw = TrimW'(r.w);
    rh = TrimW'(r.h);
    cx = TrimW'(c.x);
    cy = TrimW'(c.y);
    cw = TrimW'(c.w);
    ch = TrimW'(c.h);
    d = rx - cx;
    if (d < 0) begin
      rw = rw + d;
      rx = cx;
    end
    d = ry - cy;
    if (d < 0) begin
      rh = rh + d;
      ry = cy;
    end
    d = (rx + rw) - (cx + cw);
    if (d > 0) begin
      rw = rw - d;
    end
    d = (ry + rh) - (cy + ch);
    if (d > 0) begin
      rh = rh - d;
    end
    if (rw < 0) begin
      rw = '0;
    end
    if (rh < 0) begin
      rh = '0;
    end
    t.x = rx[CoordW-1:0];
    t.y = ry[CoordW-1:0];
    t.w = rw[CoordW-1:0];
    t.h = rh[CoordW-1:0];
    return t;
  endfunction

endpackage

[hdl/cliprs_ctrl.sv]
// ----------------------------------------------------------------------------
// cliprs_ctrl
// Request sequencing: takes one request, then commits it once the output
// register is free to take the result.
// ----------------------------------------------------------------------------
module cliprs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output cliprs_pkg::ctl_cmd_t ctl
);
  import cliprs_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    ctl.latch  = 1'b0;
    ctl.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ctl.latch = in_valid;
      end
      ST_COMMIT: begin
        ctl.commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/cliprs_dp.sv]
// ----------------------------------------------------------------------------
// cliprs_dp
// Datapath: request registers, trim logic, clip stack memory, current clip,
// window registers and the result register.
// ----------------------------------------------------------------------------
module cliprs_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cliprs_pkg::ctl_cmd_t                   ctl,
  input  logic                                   cmd,
  input  logic signed [cliprs_pkg::CoordW-1:0]   rect_x,
  input  logic signed [cliprs_pkg::CoordW-1:0]   rect_y,
  input  logic signed [cliprs_pkg::CoordW-1:0]   rect_w,
  input  logic signed [cliprs_pkg::CoordW-1:0]   rect_h,
  input  logic                                   no_intersect,
  input  logic                                   cfg_we,
  input  logic [cliprs_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [cliprs_pkg::WinW-1:0]            cfg_data,
  output logic signed [cliprs_pkg::CoordW-1:0]   clip_x,
  output logic signed [cliprs_pkg::CoordW-1:0]   clip_y,
  output logic signed [cliprs_pkg::CoordW-1:0]   clip_w,
  output logic signed [cliprs_pkg::CoordW-1:0]   clip_h,
  output logic                                   clip_on,
  output logic                                   overflow
);
  import cliprs_pkg::*;

  localparam int AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DepthW = $clog2(STACK_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthFull = DepthW'(STACK_DEPTH);
  localparam logic [DepthW-1:0] DepthOne  = DepthW'(1);
  localparam logic [DepthW-1:0] DepthTwo  = DepthW'(2);

  clip_t mem [STACK_DEPTH];
  clip_t rd_data;
  logic [AddrW-1:0] rd_addr;

  logic        req_cmd;
  clip_t       req_rect;
  logic        req_no_intersect;

  logic [DepthW-1:0] depth;
  logic [DepthW-1:0] depth_next;
  clip_t             cur;
  clip_t             cur_next;
  clip_t             push_rect;
  clip_t             window_clip;
  logic [WinW-1:0]   win_w;
  logic [WinW-1:0]   win_h;
  logic              full;
  logic              push_ok;
  logic              ovf_next;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      req_cmd          <= cmd;
      req_rect.x       <= rect_x;
      req_rect.y       <= rect_y;
      req_rect.w       <= rect_w;
      req_rect.h       <= rect_h;
      req_no_intersect <= no_intersect;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_w <= WINDOW_WIDTH_RST;
      win_h <= WINDOW_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_WIDTH:  win_w <= cfg_data;
        CFG_WINDOW_HEIGHT: win_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign window_clip.x = '0;
  assign window_clip.y = '0;
  assign window_clip.w = {1'b0, win_w};
  assign window_clip.h = {1'b0, win_h};

  // entry below the top, read ahead through the registered read so a pop finds it ready
  assign rd_addr = AddrW'(depth - DepthTwo);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (ctl.commit && push_ok) begin
      mem[depth[AddrW-1:0]] <= push_rect;
    end
  end

  assign full    = (depth == DepthFull);
  assign push_ok = (req_cmd == CMD_PUSH) && !full;

  always_comb begin
    if (depth != '0 && !req_no_intersect) begin
      push_rect = trim_clip(req_rect, cur);
    end else begin
      push_rect = req_rect;
    end
  end

  always_comb begin
    depth_next = depth;
    cur_next   = cur;
    ovf_next   = 1'b0;
    if (req_cmd == CMD_PUSH) begin
      if (full) begin
        ovf_next = 1'b1;
      end else begin
        depth_next = depth + DepthOne;
        cur_next   = push_rect;
      end
    end else if (depth != '0) begin
      depth_next = depth - DepthOne;
      if (depth == DepthOne) begin
        cur_next = window_clip;
      end else begin
        cur_next = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      cur.x   <= '0;
      cur.y   <= '0;
      cur.w   <= {1'b0, WINDOW_WIDTH_RST};
      cur.h   <= {1'b0, WINDOW_HEIGHT_RST};
    end else if (ctl.commit) begin
      depth <= depth_next;
      cur   <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      clip_x   <= cur_next.x;
      clip_y   <= cur_next.y;
      clip_w   <= cur_next.w;
      clip_h   <= cur_next.h;
      clip_on  <= (depth_next != '0);
      overflow <= ovf_next;
    end
  end

endmodule

[hdl/clip_rect_stack.sv]
// a request is latched into the request registers, then its result is
// registered once the output register is free; output stall holds it
// a new request is taken only after the last one commits, which also gives
// the stack memory's registered read its time
// reset: stack empty, clip is the full window with clipping off,
// window registers 768 by 432; stack memory contents are not cleared
// ----------------------------------------------------------------------------
// clip_rect_stack
// Clip stack: a push trims unless empty or no_intersect; a pop restores.
// ----------------------------------------------------------------------------
module clip_rect_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [cliprs_pkg::CoordW-1:0] rect_x,
  input  logic signed [cliprs_pkg::CoordW-1:0] rect_y,
  input  logic signed [cliprs_pkg::CoordW-1:0] rect_w,
  input  logic signed [cliprs_pkg::CoordW-1:0] rect_h,
  input  logic                                 no_intersect,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cliprs_pkg::CoordW-1:0] clip_x,
  output logic signed [cliprs_pkg::CoordW-1:0] clip_y,
  output logic signed [cliprs_pkg::CoordW-1:0] clip_w,
  output logic signed [cliprs_pkg::CoordW-1:0] clip_h,
  output logic                                 clip_on,
  output logic                                 overflow,
  input  logic                                 cfg_we,
  input  logic [cliprs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [cliprs_pkg::WinW-1:0]          cfg_data
);
  import cliprs_pkg::*;

  ctl_cmd_t ctl;

  cliprs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  cliprs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .no_intersect (no_intersect),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .clip_x       (clip_x),
    .clip_y       (clip_y),
    .clip_w       (clip_w),
    .clip_h       (clip_h),
    .clip_on      (clip_on),
    .overflow     (overflow)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for clip_rect_stack. A driver sends push and pop
// requests from a queue and keeps its own model of the clip stack, and a
// monitor checks each returned clip against the model's expectation. Both
// sides idle and stall at random, and the window size registers are
// rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cliprs_pkg::*;

  localparam int ClipStackDepth = 16;

  typedef struct {
    logic                     cmd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] w;
    logic signed [CoordW-1:0] h;
    logic                     no_trim;
  } clip_req_t;

  typedef struct {
    clip_t box;
    logic  on;
    logic  dropped;
  } clip_result_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cmd = CMD_POP;
  logic signed [CoordW-1:0]   rect_x = '0;
  logic signed [CoordW-1:0]   rect_y = '0;
  logic signed [CoordW-1:0]   rect_w = '0;
  logic signed [CoordW-1:0]   rect_h = '0;
  logic                       no_intersect = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [CoordW-1:0]   clip_x;
  logic signed [CoordW-1:0]   clip_y;
  logic signed [CoordW-1:0]   clip_w;
  logic signed [CoordW-1:0]   clip_h;
  logic                       clip_on;
  logic                       overflow;
  logic                       cfg_we = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index = CFG_WINDOW_WIDTH;
  logic [WinW-1:0]            cfg_data = '0;

  // shadow of the block's state
  clip_t           shadow_stack [ClipStackDepth];
  int              shadow_depth = 0;
  clip_t           shadow_clip;
  logic [WinW-1:0] shadow_win_w = WINDOW_WIDTH_RST;
  logic [WinW-1:0] shadow_win_h = WINDOW_HEIGHT_RST;

  clip_req_t    pending_reqs [$];
  clip_result_t expected_clips [$];
  clip_req_t    held_req;
  int           send_gap = 0;
  int           hold_left = 0;
  bit           drv_quiet = 1'b0;
  bit           mon_quiet = 1'b0;
  int           error_count = 0;

  clip_rect_stack #(
    .STACK_DEPTH(ClipStackDepth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .rect_x(rect_x),
    .rect_y(rect_y),
    .rect_w(rect_w),
    .rect_h(rect_h),
    .no_intersect(no_intersect),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .clip_x(clip_x),
    .clip_y(clip_y),
    .clip_w(clip_w),
    .clip_h(clip_h),
    .clip_on(clip_on),
    .overflow(overflow),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // left/top rise to the clip, right/bottom come down to it, sizes floor at 0
  function automatic clip_t trim_box(clip_t r, clip_t c);
    int    left;
    int    top;
    int    right;
    int    bottom;
    clip_t t;
    left   = (int'(r.x) > int'(c.x)) ? int'(r.x) : int'(c.x);
    top    = (int'(r.y) > int'(c.y)) ? int'(r.y) : int'(c.y);
    right  = int'(r.x) + int'(r.w);
    bottom = int'(r.y) + int'(r.h);
    if (int'(c.x) + int'(c.w) < right) right = int'(c.x) + int'(c.w);
    if (int'(c.y) + int'(c.h) < bottom) bottom = int'(c.y) + int'(c.h);
    t.x = left[CoordW-1:0];
    t.y = top[CoordW-1:0];
    t.w = (right > left) ? CoordW'(right - left) : '0;
    t.h = (bottom > top) ? CoordW'(bottom - top) : '0;
    return t;
  endfunction

  function automatic clip_result_t predict_clip(clip_req_t rq);
    clip_result_t res;
    clip_t        box;
    res.dropped = 1'b0;
    if (rq.cmd == CMD_PUSH) begin
      if (shadow_depth >= ClipStackDepth) begin
        res.dropped = 1'b1;
      end else begin
        box.x = rq.x;
        box.y = rq.y;
        box.w = rq.w;
        box.h = rq.h;
        if (shadow_depth > 0 && !rq.no_trim) box = trim_box(box, shadow_clip);
        shadow_clip = box;
        shadow_stack[shadow_depth] = box;
        shadow_depth++;
      end
    end else if (shadow_depth > 0) begin
      shadow_depth--;
      if (shadow_depth == 0) begin
        shadow_clip = '{x: '0, y: '0, w: CoordW'(shadow_win_w), h: CoordW'(shadow_win_h)};
      end else begin
        shadow_clip = shadow_stack[shadow_depth-1];
      end
    end
    res.box = shadow_clip;
    res.on  = (shadow_depth > 0);
    return res;
  endfunction

  function automatic int draw_wait();
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
  endfunction

  // mostly near the window, with extremes and full-range values mixed in
  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return CoordW'($urandom);
      default: return CoordW'($urandom_range(0, 1100)) - 16'sd150;
    endcase
  endfunction

  function automatic clip_req_t rand_req(int push_pct);
    clip_req_t rq;
    rq.cmd     = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
    rq.x       = rand_coord();
    rq.y       = rand_coord();
    rq.w       = rand_coord();
    rq.h       = rand_coord();
    rq.no_trim = ($urandom_range(0, 4) == 0);
    return rq;
  endfunction

  task automatic queue_req(logic op, int x, int y, int w, int h, logic nt);
    clip_req_t rq;
    rq.cmd     = op;
    rq.x       = x[CoordW-1:0];
    rq.y       = y[CoordW-1:0];
    rq.w       = w[CoordW-1:0];
    rq.h       = h[CoordW-1:0];
    rq.no_trim = nt;
    pending_reqs = {pending_reqs, rq};
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_clips.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic [CfgIdxW-1:0] idx, logic [WinW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW_WIDTH) shadow_win_w = val;
    else shadow_win_h = val;
  endtask

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_clips = {expected_clips, predict_clip(held_req)};
        send_gap = drv_quiet ? 0 : draw_wait();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && pending_reqs.size() != 0) begin
          held_req = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          cmd          <= held_req.cmd;
          rect_x       <= held_req.x;
          rect_y       <= held_req.y;
          rect_w       <= held_req.w;
          rect_h       <= held_req.h;
          no_intersect <= held_req.no_trim;
        end else begin
          in_valid <= 1'b0;
          if (send_gap != 0) send_gap--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    clip_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_clips.size() == 0) begin
          $display("%0t: unexpected clip result, expected none, actual x %0d y %0d w %0d h %0d",
                   $time, clip_x, clip_y, clip_w, clip_h);
          error_count++;
        end else begin
          want = expected_clips.pop_front();
          check_field("clip_x", want.box.x, clip_x);
          check_field("clip_y", want.box.y, clip_y);
          check_field("clip_w", want.box.w, clip_w);
          check_field("clip_h", want.box.h, clip_h);
          check_field("clip_on", want.on, clip_on);
          check_field("overflow", want.dropped, overflow);
        end
        hold_left = mon_quiet ? 0 : draw_wait();
      end
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin
    int push_bias [8];
    clip_req_t rq;
    push_bias = '{50, 75, 30, 60, 85, 40, 55, 25};
    shadow_clip = '{x: '0, y: '0, w: CoordW'(WINDOW_WIDTH_RST), h: CoordW'(WINDOW_HEIGHT_RST)};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    // pop with nothing stacked, fields are don't-care
    rq = rand_req(0);
    pending_reqs = {pending_reqs, rq};
    // first push is never trimmed
    queue_req(CMD_PUSH, -32768, 32767, 32767, -32768, 1'b0);
    queue_req(CMD_PUSH, 100, 50, 200, 100, 1'b0);
    // untrimmed negative size, then a trim against it
    queue_req(CMD_PUSH, 32767, -32768, -32768, 32767, 1'b1);
    queue_req(CMD_PUSH, -32768, -32768, 32767, 32767, 1'b0);
    queue_req(CMD_PUSH, 0, 0, 640, 360, 1'b1);
    for (int i = 0; i < 11; i++) begin
      queue_req(CMD_PUSH, 20 * i - 30, 15 * i - 20, 700 - 40 * i, 400 - 30 * i, 1'b0);
    end
    // stack is full now
    queue_req(CMD_PUSH, 5, 5, 10, 10, 1'b0);
    queue_req(CMD_PUSH, 32767, 32767, 32767, 32767, 1'b1);
    for (int i = 0; i < 4; i++) begin
      queue_req(CMD_POP, -32768, 32767, -32768, 32767, 1'b1);
    end
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_window(CFG_WINDOW_WIDTH, 15'd0);
          write_window(CFG_WINDOW_HEIGHT, 15'd0);
        end
        1: begin
          write_window(CFG_WINDOW_WIDTH, 15'h7fff);
          write_window(CFG_WINDOW_HEIGHT, 15'h7fff);
        end
        2: begin
          write_window(CFG_WINDOW_WIDTH, 15'd0);
          write_window(CFG_WINDOW_HEIGHT, 15'h7fff);
        end
        3: begin
          write_window(CFG_WINDOW_WIDTH, 15'h7fff);
          write_window(CFG_WINDOW_HEIGHT, 15'd0);
        end
        default: begin
          write_window(CFG_WINDOW_WIDTH, WinW'($urandom));
          write_window(CFG_WINDOW_HEIGHT, WinW'($urandom));
        end
      endcase
      @(negedge clk);
      drv_quiet = (ph == 2 || ph == 5);
      mon_quiet = (ph == 2);
      for (int i = 0; i < 235; i++) begin
        pending_reqs = {pending_reqs, rand_req(push_bias[ph])};
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
